/* hw/rtl/q5kd_pkg.sv */
// ----------------------------------------------------------------------------
// q5kd_pkg
// Shared types, constants and the scale/min unpacking function of the Q5_K
// super-block dequantiser.
// ----------------------------------------------------------------------------
package q5kd_pkg;

  localparam int unsigned VALUES_PER_RESULT = 8;
  localparam int unsigned IDX_W             = 5;
  localparam int unsigned WORD_W            = 64;
  localparam int unsigned FLOAT_W           = 32;
  localparam int unsigned QUEUE_DEPTH       = 2;
  localparam logic [IDX_W-1:0] FIRST_DATA_WORD = 5'd6;
  localparam logic [IDX_W-1:0] LAST_WORD       = 5'd21;
  localparam logic [FLOAT_W-1:0] QNAN_BITS     = 32'h7FC0_0000;

  // what a queued word is used for
  typedef enum logic [1:0] {
    KIND_HDR0,
    KIND_HDR1,
    KIND_HBITS,
    KIND_DATA
  } q5kd_kind_e;

  typedef struct packed {
    q5kd_kind_e        kind;
    logic [IDX_W-1:0]  idx;
    logic [WORD_W-1:0] word;
  } q5kd_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q5kd_qstat_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL0,
    ST_MUL1,
    ST_MUL2,
    ST_ALIGN,
    ST_ABS,
    ST_LZC,
    ST_ROUND,
    ST_OUT
  } q5kd_state_e;

  // 6-bit scale (upper half) and min (lower half) of sub-block j
  // psb holds packed scale bytes 0..11, byte 0 lowest
  function automatic logic [11:0] scale_min(input logic [95:0] psb, input logic [2:0] j);
    logic [7:0] b_j, b_j4, b_jm4;
    logic [5:0] sc, m;
    b_j   = psb[8*j +: 8];
    b_j4  = psb[8*(4'(j) + 4'd4) +: 8];
    b_jm4 = psb[8*(j & 3'd3) +: 8];
    if (!j[2]) begin
      sc = b_j[5:0];
      m  = b_j4[5:0];
    end else begin
      sc = {b_jm4[7:6], b_j4[3:0]};
      m  = {b_j[7:6], b_j4[7:4]};
    end
    return {sc, m};
  endfunction

endpackage

/* hw/rtl/q5kd_front.sv */
// ----------------------------------------------------------------------------
// q5kd_front
// Input side: takes words, drops out-of-range indexes and tags each word
// with its kind before it enters the queue.
// ----------------------------------------------------------------------------
module q5kd_front import q5kd_pkg::*; (
  input  logic              s_valid_i,
  input  logic [IDX_W-1:0]  s_index_i,
  input  logic [WORD_W-1:0] s_word_i,
  output logic              s_ready_o,
  input  q5kd_qstat_t       q_stat_i,
  output logic              push_o,
  output q5kd_entry_t       entry_o
);

  // accept whenever the queue has room; indexes past the block are dropped
  assign s_ready_o = !q_stat_i.full;
  assign push_o    = s_valid_i && !q_stat_i.full && (s_index_i <= LAST_WORD);

  // classify
  always_comb begin
    entry_o.idx  = s_index_i;
    entry_o.word = s_word_i;
    priority if (s_index_i == 5'd0) begin
      entry_o.kind = KIND_HDR0;
    end else if (s_index_i == 5'd1) begin
      entry_o.kind = KIND_HDR1;
    end else if (s_index_i < FIRST_DATA_WORD) begin
      entry_o.kind = KIND_HBITS;
    end else begin
      entry_o.kind = KIND_DATA;
    end
  end

endmodule

/* hw/rtl/q5kd_queue.sv */
// ----------------------------------------------------------------------------
// q5kd_queue
// Two-entry queue between the front and the back.
// ----------------------------------------------------------------------------
module q5kd_queue import q5kd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  q5kd_entry_t entry_i,
  input  logic        pop_i,
  output q5kd_entry_t entry_o,
  output q5kd_qstat_t stat_o
);

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);

  q5kd_entry_t          mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0]     wr_ptr_q, rd_ptr_q;
  logic [PTR_W:0]       count_q;

  assign stat_o.full  = (count_q == (PTR_W+1)'(QUEUE_DEPTH));
  assign stat_o.empty = (count_q == '0);
  assign entry_o      = mem_q[rd_ptr_q];

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

  // pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (pop_i)  rd_ptr_q <= rd_ptr_q + 1'b1;
      count_q <= count_q + (PTR_W+1)'(push_i) - (PTR_W+1)'(pop_i);
    end
  end

endmodule

/* hw/rtl/q5kd_back.sv */
// ----------------------------------------------------------------------------
// q5kd_back
// Execution side: stores header words and turns each data word into two
// results of eight float32 weights through a staged 8-lane datapath.
// ----------------------------------------------------------------------------
module q5kd_back import q5kd_pkg::*; (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  q5kd_entry_t                             entry_i,
  input  q5kd_qstat_t                             q_stat_i,
  output logic                                    pop_o,
  output logic                                    valid_o,
  input  logic                                    ready_i,
  output logic [7:0]                              first_index_o,
  output logic [VALUES_PER_RESULT-1:0][FLOAT_W-1:0] values_o,
  output logic                                    run_last_o,
  output logic                                    block_end_o
);

  localparam int unsigned NL = VALUES_PER_RESULT;

  q5kd_state_e state_q, state_d;
  logic        half_q, half_d;

  // header storage
  logic [WORD_W-1:0] hdr0_q, hdr1_q;
  logic [WORD_W-1:0] hb_mem [4];
  logic [WORD_W-1:0] hb_q;

  logic [WORD_W-1:0] word_q;
  logic [3:0]        v_q;

  // lane registers
  logic [5:0]         sc_q, m_q;
  logic [16:0]        bm_q;
  logic [10:0]        scq5_q [NL];
  logic [21:0]        pa_q   [NL];
  logic               spec_q [NL];
  logic [31:0]        specv_q[NL];
  logic signed [52:0] diff_q [NL];
  logic               zraw_q [NL];
  logic [51:0]        u_q    [NL];
  logic               sgn_q  [NL];
  logic               zero_q [NL];
  logic [5:0]         n_q    [NL];
  logic [31:0]        res_q  [NL];

  // operand decode
  logic [15:0] dh, mh;
  logic [4:0]  ea, eb, exa, exb, emin, da, db;
  logic [10:0] ma, mb;
  logic        sa, sb, nan_a, nan_b, inf_a, inf_b;
  logic [2:0]  sub;

  assign dh    = hdr0_q[15:0];
  assign mh    = hdr0_q[31:16];
  assign sa    = dh[15];
  assign sb    = mh[15];
  assign ea    = dh[14:10];
  assign eb    = mh[14:10];
  assign exa   = (ea == '0) ? 5'd1 : ea;
  assign exb   = (eb == '0) ? 5'd1 : eb;
  assign ma    = {(ea != '0), dh[9:0]};
  assign mb    = {(eb != '0), mh[9:0]};
  assign emin  = (exa < exb) ? exa : exb;
  assign da    = exa - emin;
  assign db    = exb - emin;
  assign nan_a = (ea == 5'd31) && (dh[9:0] != '0);
  assign nan_b = (eb == 5'd31) && (mh[9:0] != '0);
  assign inf_a = (ea == 5'd31) && (dh[9:0] == '0);
  assign inf_b = (eb == 5'd31) && (mh[9:0] == '0);
  assign sub   = {v_q[3:2], half_q};

  // position of the highest set bit plus one
  function automatic logic [5:0] bit_len(input logic [51:0] u);
    logic [5:0] n;
    n = '0;
    for (int i = 0; i < 52; i++) begin
      if (u[i]) n = 6'(i + 1);
    end
    return n;
  endfunction

  // round one exact difference to float32
  function automatic logic [31:0] round_lane(input logic [51:0] u, input logic [5:0] n,
                                             input logic [4:0] em, input logic s);
    logic [5:0]  sh;
    logic [51:0] rs;
    logic [23:0] keep0;
    logic        guard, sticky;
    logic [24:0] keep;
    logic [8:0]  ex;
    sh     = '0;
    rs     = '0;
    keep0  = '0;
    guard  = 1'b0;
    sticky = 1'b0;
    ex     = 9'(em) + 9'(n) + 9'd101;
    if (n <= 6'd24) begin
      keep = {1'b0, u[23:0] << (6'd24 - n)};
    end else begin
      sh     = n - 6'd24;
      rs     = u >> (sh - 6'd1);
      guard  = rs[0];
      keep0  = rs[24:1];
      sticky = |(u & ((52'd1 << (sh - 6'd1)) - 52'd1));
      keep   = 25'(keep0) + 25'(guard && (sticky || keep0[0]));
      if (keep[24]) begin
        keep = keep >> 1;
        ex   = ex + 9'd1;
      end
    end
    return {s, ex[7:0], keep[22:0]};
  endfunction

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      half_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      half_q  <= half_d;
    end
  end

  always_comb begin
    state_d = state_q;
    half_d  = half_q;
    pop_o   = 1'b0;
    valid_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (!q_stat_i.empty) begin
          pop_o = 1'b1;
          if (entry_i.kind == KIND_DATA) begin
            state_d = ST_MUL0;
            half_d  = 1'b0;
          end
        end
      end
      ST_MUL0:  state_d = ST_MUL1;
      ST_MUL1:  state_d = ST_MUL2;
      ST_MUL2:  state_d = ST_ALIGN;
      ST_ALIGN: state_d = ST_ABS;
      ST_ABS:   state_d = ST_LZC;
      ST_LZC:   state_d = ST_ROUND;
      ST_ROUND: state_d = ST_OUT;
      ST_OUT: begin
        valid_o = 1'b1;
        if (ready_i) begin
          if (!half_q) begin
            half_d  = 1'b1;
            state_d = ST_MUL0;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // high-bit rows, registered read
  always_ff @(posedge clk_i) begin
    if (pop_o && entry_i.kind == KIND_HBITS) begin
      hb_mem[2'(entry_i.idx - 5'd2)] <= entry_i.word;
    end
    hb_q <= hb_mem[v_q[1:0]];
  end

  // header words and work item
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      unique case (entry_i.kind)
        KIND_HDR0:  hdr0_q <= entry_i.word;
        KIND_HDR1:  hdr1_q <= entry_i.word;
        KIND_HBITS: ;
        KIND_DATA: begin
          word_q <= entry_i.word;
          v_q    <= 4'(entry_i.idx - FIRST_DATA_WORD);
        end
        default: ;
      endcase
    end
  end

  // lane datapath, one stage per state
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_MUL0: {sc_q, m_q} <= scale_min({hdr1_q, hdr0_q[63:32]}, sub);
      ST_MUL1: begin
        bm_q <= mb * m_q;
        for (int k = 0; k < NL; k++) begin
          scq5_q[k] <= sc_q * {hb_q[8*k + int'(sub)],
                               (half_q ? word_q[8*k+4 +: 4] : word_q[8*k +: 4])};
        end
      end
      ST_MUL2: begin
        for (int k = 0; k < NL; k++) begin
          pa_q[k] <= ma * scq5_q[k];
          if (nan_a || nan_b || (inf_a && scq5_q[k] == '0) || (inf_b && m_q == '0)) begin
            spec_q[k]  <= 1'b1;
            specv_q[k] <= QNAN_BITS;
          end else if (inf_a && inf_b) begin
            spec_q[k]  <= 1'b1;
            specv_q[k] <= (sa == sb) ? QNAN_BITS : {sa, 8'hFF, 23'd0};
          end else if (inf_a) begin
            spec_q[k]  <= 1'b1;
            specv_q[k] <= {sa, 8'hFF, 23'd0};
          end else if (inf_b) begin
            spec_q[k]  <= 1'b1;
            specv_q[k] <= {!sb, 8'hFF, 23'd0};
          end else begin
            spec_q[k]  <= 1'b0;
            specv_q[k] <= QNAN_BITS;
          end
        end
      end
      ST_ALIGN: begin
        for (int k = 0; k < NL; k++) begin
          diff_q[k] <= (sa ? -$signed({2'b00, 51'(pa_q[k]) << da})
                           :  $signed({2'b00, 51'(pa_q[k]) << da}))
                     - (sb ? -$signed({2'b00, 51'(bm_q) << db})
                           :  $signed({2'b00, 51'(bm_q) << db}));
          zraw_q[k] <= (pa_q[k] == '0) && (bm_q == '0);
        end
      end
      ST_ABS: begin
        for (int k = 0; k < NL; k++) begin
          sgn_q[k]  <= diff_q[k][52];
          u_q[k]    <= diff_q[k][52] ? 52'(-diff_q[k]) : 52'(diff_q[k]);
          zero_q[k] <= (diff_q[k] == '0);
        end
      end
      ST_LZC: begin
        for (int k = 0; k < NL; k++) begin
          n_q[k] <= bit_len(u_q[k]);
        end
      end
      ST_ROUND: begin
        for (int k = 0; k < NL; k++) begin
          if (spec_q[k]) begin
            res_q[k] <= specv_q[k];
          end else if (zero_q[k]) begin
            res_q[k] <= (zraw_q[k] && sa && !sb) ? 32'h8000_0000 : 32'd0;
          end else begin
            res_q[k] <= round_lane(u_q[k], n_q[k], emin, sgn_q[k]);
          end
        end
      end
      default: ;
    endcase
  end

  // result fields
  assign first_index_o = {v_q[3:2], half_q, v_q[1:0], 3'b000};
  assign run_last_o    = half_q;
  assign block_end_o   = half_q && (v_q == 4'(LAST_WORD - FIRST_DATA_WORD));
  always_comb begin
    for (int k = 0; k < NL; k++) begin
      values_o[k] = res_q[k];
    end
  end

endmodule

/* hw/rtl/q5k_superblock_dequantizer_top.sv */
// ----------------------------------------------------------------------------
// q5k_superblock_dequantizer_top
// Q5_K super-block dequantiser with stream input and output.
// ----------------------------------------------------------------------------
// Feed the 22 words of a super-block with their index; words 0..5 (scales,
// mins, high bits) are stored and give no output, each word 6..21 gives two
// transactions of eight float32 weights, low nibbles first (tlast low), then
// high nibbles (tlast high); tuser marks elements 248..255. Header words must
// precede the data words that use them. Words enter a two-entry queue; the
// back end pops header words only while idle and runs each result through
// seven datapath stages plus an output state, taking no new word until both
// results of a data word are accepted. Indexes above 21 are dropped.
module q5k_superblock_dequantizer_top import q5kd_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [71:0]  s_axis_tdata,  // word_index[4:0], block_word[68:5]
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [263:0] m_axis_tdata,  // first_index[7:0], value_0..value_7 (32 each)
  output logic         m_axis_tlast,  // run_last
  output logic         m_axis_tuser   // block_end
);

  q5kd_qstat_t q_stat;
  q5kd_entry_t push_entry, head_entry;
  logic        push, pop;
  logic [7:0]  first_index;
  logic [VALUES_PER_RESULT-1:0][FLOAT_W-1:0] values;

  q5kd_front u_front (
    .s_valid_i (s_axis_tvalid),
    .s_index_i (s_axis_tdata[4:0]),
    .s_word_i  (s_axis_tdata[68:5]),
    .s_ready_o (s_axis_tready),
    .q_stat_i  (q_stat),
    .push_o    (push),
    .entry_o   (push_entry)
  );

  q5kd_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .pop_i   (pop),
    .entry_o (head_entry),
    .stat_o  (q_stat)
  );

  q5kd_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .entry_i       (head_entry),
    .q_stat_i      (q_stat),
    .pop_o         (pop),
    .valid_o       (m_axis_tvalid),
    .ready_i       (m_axis_tready),
    .first_index_o (first_index),
    .values_o      (values),
    .run_last_o    (m_axis_tlast),
    .block_end_o   (m_axis_tuser)
  );

  // value_0 sits just above first_index
  assign m_axis_tdata = {values, first_index};

endmodule

/* hw/rtl/q5kd_checker.sv */
// ----------------------------------------------------------------------------
// q5kd_checker
// Port-level checks on the dequantiser output stream.
// ----------------------------------------------------------------------------
module q5kd_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [263:0] m_axis_tdata,
  input logic         m_axis_tlast,
  input logic         m_axis_tuser
);

  // a stalled transaction keeps its payload
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("output payload changed under stall");

  // end of block only on the high-nibble result
  a_end_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tlast)
    else $error("block end without tlast");

  // end of block carries elements 248..255
  a_end_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[7:0] == 8'd248)
    else $error("block end at wrong index");

  // high-nibble result follows its low-nibble partner at index + 32
  a_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready && !m_axis_tlast |=>
      !m_axis_tvalid || (m_axis_tlast &&
        m_axis_tdata[7:0] == $past(m_axis_tdata[7:0]) + 8'd32))
    else $error("low/high result pairing broken");

endmodule

bind q5k_superblock_dequantizer_top q5kd_checker u_q5kd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast),
  .m_axis_tuser  (m_axis_tuser)
);

/* tb/q5k_superblock_dequantizer_top_test.sv */
// ----------------------------------------------------------------------------
// q5k_superblock_dequantizer_top_test
// Self-checking bench for the Q5_K super-block dequantiser. Whole super-blocks
// and some out-of-order or dropped words are streamed in. A predictor computes
// every float32 weight to the bit, and each output transaction is compared
// against the oldest predicted result.
// ----------------------------------------------------------------------------
module q5k_superblock_dequantizer_top_test;
  import q5kd_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT   = 600000;
  localparam int unsigned TARGET_ITEMS  = 1250;
  localparam int unsigned DRAIN_CYCLES  = 60;
  localparam logic [4:0]  NUM_WORDS     = 5'd22;
  localparam logic [31:0] FP32_NEG_ZERO = 32'h8000_0000;
  localparam logic [31:0] FP32_INF      = 32'h7F80_0000;

  // one predicted output transaction
  typedef struct {
    logic [7:0]  first_index;
    logic [31:0] value [VALUES_PER_RESULT];
    logic        run_last;
    logic        block_end;
  } weight_row_t;

  // --------------------------------------------------------------------------
  // predictor and scoreboard
  // --------------------------------------------------------------------------
  class dequant_scoreboard;
    logic [15:0]   d_half;
    logic [15:0]   dmin_half;
    logic [7:0]    scale_bytes [12];
    logic [7:0]    qh_bytes [32];
    weight_row_t   pending_rows [$];
    int unsigned   mismatches;

    function new();
      d_half    = '0;
      dmin_half = '0;
      foreach (scale_bytes[i]) scale_bytes[i] = '0;
      foreach (qh_bytes[i]) qh_bytes[i] = '0;
      mismatches = 0;
    endfunction

    task report(string what);
      $display("%0t mismatch: %s", $realtime, what);
      mismatches++;
    endtask

    // six-bit scale and min of sub-block j
    function void sub_scale(input int unsigned j, output int unsigned sc,
                            output int unsigned mn);
      if (j < 4) begin
        sc = scale_bytes[j] & 8'h3F;
        mn = scale_bytes[j+4] & 8'h3F;
      end else begin
        sc = (scale_bytes[j+4] & 8'h0F) | ((scale_bytes[j-4] >> 6) << 4);
        mn = (scale_bytes[j+4] >> 4) | ((scale_bytes[j] >> 6) << 4);
      end
    endfunction

    // d*sc*q5 - dmin*mn, exact products, one rounding to nearest even
    function logic [31:0] fp_weight(int unsigned sc, int unsigned q5, int unsigned mn);
      logic        sa, sb, nan_a, nan_b, inf_a, inf_b, neg;
      logic [4:0]  ea, eb;
      logic [63:0] ma, mb, a, b, u, rem, halfway;
      int          xa, xb, emin, n, sh;
      longint      diff;
      logic [31:0] keep, expf;
      sa = d_half[15];
      sb = dmin_half[15];
      ea = d_half[14:10];
      eb = dmin_half[14:10];
      nan_a = (ea == 5'h1F) && (d_half[9:0] != 0);
      nan_b = (eb == 5'h1F) && (dmin_half[9:0] != 0);
      inf_a = (ea == 5'h1F) && !nan_a;
      inf_b = (eb == 5'h1F) && !nan_b;
      if (nan_a || nan_b) return QNAN_BITS;
      if (inf_a && sc * q5 == 0) return QNAN_BITS;
      if (inf_b && mn == 0) return QNAN_BITS;
      if (inf_a && inf_b) return (sa == sb) ? QNAN_BITS : ({sa, 31'h0} | FP32_INF);
      if (inf_a) return {sa, 31'h0} | FP32_INF;
      if (inf_b) return {!sb, 31'h0} | FP32_INF;
      // finite halves as mantissa * 2^exponent
      if (ea == 0) begin ma = d_half[9:0]; xa = -24; end
      else begin ma = {54'h1, d_half[9:0]}; xa = int'(ea) - 25; end
      if (eb == 0) begin mb = dmin_half[9:0]; xb = -24; end
      else begin mb = {54'h1, dmin_half[9:0]}; xb = int'(eb) - 25; end
      emin = (xa < xb) ? xa : xb;
      a = (ma * sc * q5) << (xa - emin);
      b = (mb * mn) << (xb - emin);
      diff = (sa ? -longint'(a) : longint'(a)) - (sb ? -longint'(b) : longint'(b));
      if (diff == 0) return (a == 0 && b == 0 && sa && !sb) ? FP32_NEG_ZERO : '0;
      neg = diff < 0;
      u = neg ? 64'(-diff) : 64'(diff);
      n = 0;
      while (n < 64 && (u >> n) != 0) n++;
      sh = n - 24;
      if (sh <= 0) begin
        keep = 32'(u << (-sh));
      end else begin
        rem = u & ((64'd1 << sh) - 1);
        halfway = 64'd1 << (sh - 1);
        keep = 32'(u >> sh);
        if (rem > halfway || (rem == halfway && keep[0])) keep++;
        if (keep[24]) begin keep = keep >> 1; sh++; end
      end
      expf = 32'(emin + sh + 150);
      return {neg, 31'h0} | (expf << 23) | (keep & 32'h7F_FFFF);
    endfunction

    // accepted input word: update stored header or predict two rows
    function void note_word(logic [4:0] w, logic [63:0] word);
      int unsigned p, chunk, l0, sub, sc, mn, nib, q5;
      logic [7:0]  bt;
      weight_row_t row;
      if (w > LAST_WORD) return;
      if (w < FIRST_DATA_WORD) begin
        for (int k = 0; k < 8; k++) begin
          p = w * 8 + k;
          bt = word[8*k +: 8];
          if (p == 0) d_half[7:0] = bt;
          else if (p == 1) d_half[15:8] = bt;
          else if (p == 2) dmin_half[7:0] = bt;
          else if (p == 3) dmin_half[15:8] = bt;
          else if (p < 16) scale_bytes[p-4] = bt;
          else qh_bytes[p-16] = bt;
        end
        return;
      end
      chunk = ((w - 6) * 8) >> 5;
      l0 = ((w - 6) * 8) & 31;
      for (int hi = 0; hi < 2; hi++) begin
        sub = chunk * 2 + hi;
        sub_scale(sub, sc, mn);
        row.first_index = 8'(chunk * 64 + hi * 32 + l0);
        for (int k = 0; k < VALUES_PER_RESULT; k++) begin
          bt = word[8*k +: 8];
          nib = hi ? bt[7:4] : bt[3:0];
          q5 = nib + (qh_bytes[l0+k][sub] ? 16 : 0);
          row.value[k] = fp_weight(sc, q5, mn);
        end
        row.run_last = hi[0];
        row.block_end = (hi == 1) && (w == LAST_WORD);
        pending_rows.push_back(row);
      end
    endfunction

    task check_row(logic [263:0] data, logic last, logic user);
      weight_row_t want;
      if (pending_rows.size() == 0) begin
        report("output transaction with nothing predicted");
        return;
      end
      want = pending_rows.pop_front();
      if (data[7:0] !== want.first_index)
        report($sformatf("first_index %0d, predicted %0d", data[7:0], want.first_index));
      for (int k = 0; k < VALUES_PER_RESULT; k++)
        if (data[8+32*k +: 32] !== want.value[k])
          report($sformatf("element %0d: %h, predicted %h",
                           want.first_index + k, data[8+32*k +: 32], want.value[k]));
      if (last !== want.run_last)
        report($sformatf("tlast %b at element %0d", last, want.first_index));
      if (user !== want.block_end)
        report($sformatf("tuser %b at element %0d", user, want.first_index));
    endtask
  endclass

  // --------------------------------------------------------------------------
  // clock, reset, DUT
  // --------------------------------------------------------------------------
  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [71:0]  s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [263:0] m_axis_tdata;
  logic         m_axis_tlast;
  logic         m_axis_tuser;

  dequant_scoreboard sb = new();
  int unsigned cycle_count = 0;
  int unsigned counted_items = 0;
  bit          quiet_phase = 1'b0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  q5k_superblock_dequantizer_top u_top (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast, .m_axis_tuser
  );

  // watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // output side: random stall bursts, check every transaction
  int unsigned stall_left = 0;
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      sb.check_row(m_axis_tdata, m_axis_tlast, m_axis_tuser);
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      m_axis_tready <= 1'b0;
    end else if (!quiet_phase && $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 4);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // --------------------------------------------------------------------------
  // stimulus
  // --------------------------------------------------------------------------
  task automatic send_word(logic [4:0] w, logic [63:0] word);
    int unsigned gap;
    if (!quiet_phase && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 5);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {3'b000, word, w};
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_word(w, word);
    if (w <= LAST_WORD) counted_items++;
  endtask

  // mostly ordinary normals, with the awkward encodings mixed in
  function automatic logic [15:0] pick_half();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return {1'($urandom), 5'($urandom_range(5, 20)), 10'($urandom)};
    if (r < 70) return {1'($urandom), 5'd0, 10'($urandom)};
    if (r < 75) return {1'($urandom), 15'd0};
    if (r < 80) return {1'($urandom), 5'h1F, 10'd0};
    if (r < 84) return {1'($urandom), 5'h1F, 10'($urandom_range(1, 1023))};
    if (r < 88) return {1'($urandom), 5'h1E, 10'h3FF};
    return 16'($urandom);
  endfunction

  function automatic logic [63:0] pick_word(logic [4:0] w);
    logic [63:0] word;
    word = {$urandom, $urandom};
    if (w == 0) word[31:0] = {pick_half(), pick_half()};
    return word;
  endfunction

  task automatic send_block();
    for (logic [4:0] w = 0; w < NUM_WORDS; w++) send_word(w, pick_word(w));
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: saturated block with a normal scale, then special halves
    send_word(5'd0, {32'hFFFF_FFFF, 16'h3C00, 16'h3C00});
    for (logic [4:0] w = 1; w < NUM_WORDS; w++) send_word(w, '1);
    send_word(5'd0, {32'hFFFF_FFFF, 16'hFC00, 16'h7C00});  // +inf d minus -inf dmin
    send_word(5'd6, 64'h0000_0000_FFFF_FFFF);
    send_word(5'd0, {32'h0000_0000, 16'h7E01, 16'h0001});   // NaN min
    send_word(5'd21, '0);
    send_word(5'd0, {32'h3F3F_3F3F, 16'h8000, 16'h8000});   // both zero
    send_word(5'd13, '0);
    send_word(5'd31, '1);                                    // dropped index

    // random: mostly whole blocks, some scattered or dropped words
    while (counted_items < TARGET_ITEMS) begin
      if (counted_items > TARGET_ITEMS - 150) quiet_phase = 1'b1;
      if ($urandom_range(0, 99) < 85) begin
        send_block();
      end else begin
        repeat ($urandom_range(1, 8)) begin
          logic [4:0] w;
          w = 5'($urandom);
          send_word(w, pick_word(w));
        end
      end
    end
    s_axis_tvalid <= 1'b0;

    while (sb.pending_rows.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

/* files.f */
hw/rtl/q5kd_pkg.sv
hw/rtl/q5kd_front.sv
hw/rtl/q5kd_queue.sv
hw/rtl/q5kd_back.sv
hw/rtl/q5k_superblock_dequantizer_top.sv
hw/rtl/q5kd_checker.sv
tb/q5k_superblock_dequantizer_top_test.sv
